/* src/ccs_pkg.sv */
// Shared types and constants for the character class statistics block.
// Holds the class codes, the controller states and the character classifier.
// No dependencies.
package ccs_pkg;

    localparam int BYTE_DEPTH = 256;
    localparam int PAIR_DEPTH = 25;
    localparam int MASK_W     = 64;
    localparam int DATA_W     = 32;

    localparam logic [7:0] UPPER_FIRST = 8'h41;
    localparam logic [7:0] UPPER_LAST  = 8'h5A;
    localparam logic [7:0] LOWER_FIRST = 8'h61;
    localparam logic [7:0] LOWER_LAST  = 8'h7A;
    localparam logic [7:0] DIGIT_FIRST = 8'h30;
    localparam logic [7:0] DIGIT_LAST  = 8'h39;

    localparam logic [1:0] CFG_MASK_0 = 2'd0;
    localparam logic [1:0] CFG_MASK_1 = 2'd1;
    localparam logic [1:0] CFG_MASK_2 = 2'd2;
    localparam logic [1:0] CFG_MASK_3 = 2'd3;

    typedef enum logic [2:0] {
        CLS_UPPER   = 3'd0,
        CLS_LOWER   = 3'd1,
        CLS_DIGIT   = 3'd2,
        CLS_SPECIAL = 3'd3,
        CLS_OTHER   = 3'd4,
        CLS_NOTHING = 3'd5
    } cls_t;

    typedef enum logic [1:0] {
        BANK_NONE,
        BANK_BYTE,
        BANK_PLACE,
        BANK_PAIR
    } bank_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

    function automatic cls_t classify(input logic [7:0] b, input logic [255:0] mask);
        cls_t c;
        if (b inside {[UPPER_FIRST:UPPER_LAST]})
            c = CLS_UPPER;
        else if (b inside {[LOWER_FIRST:LOWER_LAST]})
            c = CLS_LOWER;
        else if (b inside {[DIGIT_FIRST:DIGIT_LAST]})
            c = CLS_DIGIT;
        else if (mask[b])
            c = CLS_SPECIAL;
        else
            c = CLS_NOTHING;
        return c;
    endfunction

endpackage

/* src/ccs_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for every counter bank of the statistics block. No dependencies.
module ccs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/char_class_statistics.sv */
// Character class statistics: byte, place and pair counters in three RAM banks.
// Accepted item and RAM read data are registered; a read item then sets out_valid
// from its register and a count item writes back its counters from the read data.
// A new item is taken only when the last is done (RAM read, then write-back); a
// read item also waits while an earlier result is still held. Reset (async, active
// low) zeroes the masks and starts a clearing pass over the counters, in_ready low.
module char_class_statistics
    import ccs_pkg::*;
#(
    parameter int PLACE_LIMIT = 20,
    parameter int COUNT_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [MASK_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [7:0]          char_code,
    input  logic [7:0]          next_code,
    input  logic [7:0]          char_pos,
    input  logic [7:0]          word_len,
    input  logic [8:0]          read_addr,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DATA_W-1:0]   read_data
);

    localparam int PLACE_DEPTH = 4 * PLACE_LIMIT;
    localparam int PA_W        = $clog2(PLACE_DEPTH);
    localparam int PAIR_BASE   = BYTE_DEPTH + PLACE_DEPTH;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               is_read;
        logic               byte_we;
        logic               place_we;
        logic               pair_we;
        bank_t              bank;
        logic [7:0]         byte_addr;
        logic [PA_W-1:0]    place_addr;
        logic [4:0]         pair_addr;
    } item_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [255:0]           mask_reg, mask_next;
    logic [7:0]             clr_reg, clr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]      read_data_reg, read_data_next;

    logic [7:0]             len_mod [BYTE_DEPTH];
    logic                   in_acc;
    logic                   done;
    logic                   counted;
    logic                   clearing;
    logic                   clr_place, clr_pair;
    cls_t                   cls_cur, cls_nxt, first, follow;
    logic [9:0]             addr_ext, pair_off;
    logic [COUNT_BITS-1:0]  byte_rdata, place_rdata, pair_rdata, sel_val;
    logic [COUNT_BITS-1:0]  byte_wdata, place_wdata, pair_wdata;
    logic                   byte_we, place_we, pair_we;
    logic [7:0]             byte_waddr;
    logic [PA_W-1:0]        place_waddr;
    logic [4:0]             pair_waddr;
    logic [63:0]            sel_wide;

    // Word length modulo the place limit, as a constant table.
    for (genvar g = 0; g < BYTE_DEPTH; g++)
    begin : g_len_mod
        assign len_mod[g] = 8'(g % PLACE_LIMIT);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    // Decode of the incoming item; RAM reads are issued in the accept cycle.
    always_comb
    begin
        cls_cur  = classify(char_code, mask_reg);
        cls_nxt  = classify(next_code, mask_reg);
        first    = (cls_cur == CLS_NOTHING) ? CLS_OTHER : cls_cur;
        follow   = (cls_nxt == CLS_NOTHING && next_code == 8'd0) ? CLS_OTHER : cls_nxt;
        counted  = (char_pos < len_mod[word_len]);
        addr_ext = {1'b0, read_addr};
        pair_off = addr_ext - 10'(PAIR_BASE);

        item_next = '0;
        item_next.is_read = req_type;
        if (req_type)
        begin
            item_next.byte_addr  = read_addr[7:0];
            item_next.place_addr = read_addr[PA_W-1:0];
            item_next.pair_addr  = pair_off[4:0];
            if (addr_ext < 10'(BYTE_DEPTH))
                item_next.bank = BANK_BYTE;
            else if (addr_ext < 10'(PAIR_BASE))
                item_next.bank = BANK_PLACE;
            else if (addr_ext < 10'(PAIR_BASE + PAIR_DEPTH))
                item_next.bank = BANK_PAIR;
            else
                item_next.bank = BANK_NONE;
        end
        else
        begin
            item_next.byte_addr  = char_code;
            item_next.place_addr = PA_W'({2'b00, char_pos, first[1:0]});
            item_next.pair_addr  = 5'({first, 2'b00}) + 5'(first) + 5'(follow);
            item_next.byte_we    = counted;
            item_next.place_we   = counted && (cls_cur != CLS_NOTHING);
            item_next.pair_we    = counted && (follow != CLS_NOTHING);
        end
    end

    // Write ports: zeros during the clearing pass, incremented counters afterwards.
    always_comb
    begin
        clearing    = (state_reg == ST_CLEAR);
        clr_place   = clearing && ({1'b0, clr_reg} < 9'(PLACE_DEPTH));
        clr_pair    = clearing && (clr_reg < 8'(PAIR_DEPTH));
        byte_we     = clearing || (done && item_reg.byte_we);
        place_we    = clr_place || (done && item_reg.place_we);
        pair_we     = clr_pair || (done && item_reg.pair_we);
        byte_waddr  = clearing ? clr_reg : item_reg.byte_addr;
        place_waddr = clearing ? PA_W'(clr_reg) : item_reg.place_addr;
        pair_waddr  = clearing ? clr_reg[4:0] : item_reg.pair_addr;
        byte_wdata  = clearing ? '0 : sat_inc(byte_rdata);
        place_wdata = clearing ? '0 : sat_inc(place_rdata);
        pair_wdata  = clearing ? '0 : sat_inc(pair_rdata);
    end

    ccs_ram #(.WIDTH(COUNT_BITS), .DEPTH(BYTE_DEPTH)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (byte_wdata),
        .re    (in_acc),
        .raddr (item_next.byte_addr),
        .rdata (byte_rdata)
    );

    ccs_ram #(.WIDTH(COUNT_BITS), .DEPTH(PLACE_DEPTH)) u_place_ram (
        .clk   (clk),
        .we    (place_we),
        .waddr (place_waddr),
        .wdata (place_wdata),
        .re    (in_acc),
        .raddr (item_next.place_addr),
        .rdata (place_rdata)
    );

    ccs_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .re    (in_acc),
        .raddr (item_next.pair_addr),
        .rdata (pair_rdata)
    );

    always_comb
    begin
        case (item_reg.bank)
            BANK_BYTE:  sel_val = byte_rdata;
            BANK_PLACE: sel_val = place_rdata;
            BANK_PAIR:  sel_val = pair_rdata;
            default:    sel_val = '0;
        endcase
        sel_wide = 64'(sel_val);
    end

    always_comb
    begin
        done = (state_reg == ST_BUSY) && (!item_reg.is_read || !out_valid_reg || out_ready);

        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 8'd1;
                if (clr_reg == 8'(BYTE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE: if (in_acc) state_next = ST_BUSY;
            ST_BUSY: if (done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        read_data_next = read_data_reg;
        if (done && item_reg.is_read)
        begin
            out_valid_next = 1'b1;
            read_data_next = (|sel_wide[63:32]) ? '1 : sel_wide[31:0];
        end

        mask_next = mask_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MASK_0: mask_next[63:0]    = cfg_data;
                CFG_MASK_1: mask_next[127:64]  = cfg_data;
                CFG_MASK_2: mask_next[191:128] = cfg_data;
                CFG_MASK_3: mask_next[255:192] = cfg_data;
                default:    mask_next = mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= item_next;
        end
        read_data_reg <= read_data_next;
    end

endmodule

/* src/ccs_checker.sv */
// Port-level checks for the character class statistics block.
// Depends on ccs_pkg; bound to char_class_statistics at the end of this file.
module ccs_checker
    import ccs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              req_type,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] read_data
);

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while the previous one was in flight");

    // No result can appear in the cycle right after an item is accepted.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    // A read item accepted with a free output slot delivers its result.
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type && !out_valid |-> ##2 out_valid)
        else $error("read item gave no result");

endmodule

bind char_class_statistics ccs_checker u_ccs_checker (.*);

/* verif/tb.sv */
// Testbench for char_class_statistics: directed rows, then random word streams under
// several special-character masks, every read checked by a predictor or a fixed value.
// Depends on ccs_pkg and the char_class_statistics top level.
module tb
    import ccs_pkg::*;
();

    localparam int          PLACE_LIMIT = 20;
    localparam int          PLACE_BASE  = 256;
    localparam int          PAIR_BASE   = PLACE_BASE + 4 * PLACE_LIMIT;
    localparam bit          REQ_COUNT   = 1'b0;
    localparam bit          REQ_READ    = 1'b1;
    localparam int          RUN_LIMIT   = 2000000;

    typedef enum bit { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        bit          req;
        bit [7:0]    cur;
        bit [7:0]    nxt;
        bit [7:0]    pos;
        bit [7:0]    len;
        bit [8:0]    addr;
        bit [1:0]    cfg_idx;
        bit [63:0]   cfg_val;
        bit          typed;
        bit [31:0]   want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_addr;
    logic [MASK_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              req_type;
    logic [7:0]        char_code;
    logic [7:0]        next_code;
    logic [7:0]        char_pos;
    logic [7:0]        word_len;
    logic [8:0]        read_addr;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] read_data;

    // Predicted state of the block.
    bit [255:0]        spec_mask;
    bit [31:0]         byte_tally [256];
    bit [31:0]         place_tally[4*PLACE_LIMIT];
    bit [31:0]         pair_tally [25];

    bit [31:0]         reads_due[$];
    stim_row_t         directed_rows[$];
    int                mismatches;
    int                items_sent;
    bit                idle_on;

    char_class_statistics #(.PLACE_LIMIT(PLACE_LIMIT), .COUNT_BITS(32)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .char_code (char_code),
        .next_code (next_code),
        .char_pos  (char_pos),
        .word_len  (word_len),
        .read_addr (read_addr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #(RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    function automatic cls_t class_of(input bit [7:0] b);
        if (b >= UPPER_FIRST && b <= UPPER_LAST)
            return CLS_UPPER;
        if (b >= LOWER_FIRST && b <= LOWER_LAST)
            return CLS_LOWER;
        if (b >= DIGIT_FIRST && b <= DIGIT_LAST)
            return CLS_DIGIT;
        return spec_mask[b] ? CLS_SPECIAL : CLS_NOTHING;
    endfunction

    function automatic bit [31:0] bumped(input bit [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    task automatic tally_char(input bit [7:0] cur, input bit [7:0] nxt,
                              input bit [7:0] pos, input bit [7:0] len);
        cls_t first;
        cls_t follow;
        if (pos >= len % PLACE_LIMIT)
            return;
        first = class_of(cur);
        if (first == CLS_NOTHING)
            first = CLS_OTHER;
        else
            place_tally[pos*4 + int'(first)] = bumped(place_tally[pos*4 + int'(first)]);
        byte_tally[cur] = bumped(byte_tally[cur]);
        follow = class_of(nxt);
        // A zero that is not marked special closes the word.
        if (follow == CLS_NOTHING && nxt == 8'd0)
            follow = CLS_OTHER;
        if (follow != CLS_NOTHING)
            pair_tally[int'(first)*5 + int'(follow)] =
                bumped(pair_tally[int'(first)*5 + int'(follow)]);
    endtask

    function automatic bit [31:0] counter_at(input bit [8:0] addr);
        if (addr < PLACE_BASE)
            return byte_tally[addr];
        if (addr < PAIR_BASE)
            return place_tally[addr - PLACE_BASE];
        if (addr < PAIR_BASE + 25)
            return pair_tally[addr - PAIR_BASE];
        return 32'd0;
    endfunction

    task automatic send_req(input bit rq, input bit [7:0] cur, input bit [7:0] nxt,
                            input bit [7:0] pos, input bit [7:0] len, input bit [8:0] addr,
                            input bit typed, input bit [31:0] want);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rq;
        char_code <= cur;
        next_code <= nxt;
        char_pos  <= pos;
        word_len  <= len;
        read_addr <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (rq == REQ_READ)
            reads_due.push_back(typed ? want : counter_at(addr));
        else
            tally_char(cur, nxt, pos, len);
    endtask

    // Hold the sender until every read has answered and a count in flight has retired.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reads_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(input bit [1:0] idx, input bit [63:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        spec_mask[idx*64 +: 64] = val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_masks(input bit [63:0] m0, input bit [63:0] m1,
                             input bit [63:0] m2, input bit [63:0] m3);
        write_mask(CFG_MASK_0, m0);
        write_mask(CFG_MASK_1, m1);
        write_mask(CFG_MASK_2, m2);
        write_mask(CFG_MASK_3, m3);
    endtask

    function automatic bit [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 8'($urandom_range(UPPER_FIRST, UPPER_LAST));
        if (r < 50)
            return 8'($urandom_range(LOWER_FIRST, LOWER_LAST));
        if (r < 65)
            return 8'($urandom_range(DIGIT_FIRST, DIGIT_LAST));
        if (r < 85)
            return 8'($urandom_range(8'h21, 8'h2F));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic bit [8:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 9'($urandom_range(0, PLACE_BASE - 1));
        if (r < 65)
            return 9'($urandom_range(PLACE_BASE, PAIR_BASE - 1));
        if (r < 85)
            return 9'($urandom_range(PAIR_BASE, PAIR_BASE + 24));
        return 9'($urandom_range(0, 511));
    endfunction

    task automatic read_random();
        send_req(REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 pick_addr(), 1'b0, 32'd0);
    endtask

    // Mostly whole words in order, with reads mixed in; the rest is loose noise.
    task automatic run_random(input int n);
        int        stop;
        int        r;
        int        len;
        int        n_emit;
        bit [7:0]  wch[257];
        bit [7:0]  follow;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 255)
                                                  : $urandom_range(1, 19);
                n_emit = (len < PLACE_LIMIT) ? len : len % PLACE_LIMIT + 2;
                if (n_emit > len)
                    n_emit = len;
                for (int i = 0; i <= n_emit; i++)
                    wch[i] = (i < len) ? pick_char() : 8'd0;
                for (int i = 0; i < n_emit; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        read_random();
                    follow = wch[i+1];
                    send_req(REQ_COUNT, wch[i], follow, 8'(i), 8'(len), 9'($urandom),
                             1'b0, 32'd0);
                end
            end
            else if (r < 85)
            begin
                repeat ($urandom_range(1, 4)) read_random();
            end
            else
            begin
                send_req(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 9'($urandom_range(0, 511)), 1'b0, 32'd0);
            end
        end
    endtask

    function automatic stim_row_t count_row(input bit [7:0] cur, input bit [7:0] nxt,
                                            input bit [7:0] pos, input bit [7:0] len);
        stim_row_t row;
        row = '{kind: ROW_ITEM, req: REQ_COUNT, cur: cur, nxt: nxt, pos: pos, len: len,
                default: '0};
        return row;
    endfunction

    function automatic stim_row_t read_row(input bit [8:0] addr, input bit typed,
                                           input bit [31:0] want);
        stim_row_t row;
        row = '{kind: ROW_ITEM, req: REQ_READ, addr: addr, typed: typed, want: want,
                default: '0};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input bit [1:0] idx, input bit [63:0] val);
        stim_row_t row;
        row = '{kind: ROW_CFG, cfg_idx: idx, cfg_val: val, default: '0};
        return row;
    endfunction

    // Receiver: random stall bursts while idling is on.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_reads
        bit [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (reads_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual read_data %h",
                         $time, read_data);
                mismatches++;
            end
            else
            begin
                want = reads_due.pop_front();
                if (read_data !== want)
                begin
                    $display("%0t: read_data mismatch, expected %h, actual %h",
                             $time, want, read_data);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = REQ_COUNT;
        char_code  = '0;
        next_code  = '0;
        char_pos   = '0;
        word_len   = '0;
        read_addr  = '0;
        spec_mask  = '0;
        mismatches = 0;
        items_sent = 0;
        idle_on    = 1'b1;
        foreach (byte_tally[i])
            byte_tally[i] = '0;
        foreach (place_tally[i])
            place_tally[i] = '0;
        foreach (pair_tally[i])
            pair_tally[i] = '0;

        // Directed rows; the counters are all zero and the masks clear after reset.
        directed_rows.push_back(read_row(9'd0, 1'b1, 32'd0));
        directed_rows.push_back(read_row(9'd511, 1'b1, 32'd0));
        directed_rows.push_back(read_row(9'(PAIR_BASE + 24), 1'b1, 32'd0));
        directed_rows.push_back(count_row("A", "b", 8'd0, 8'd5));
        directed_rows.push_back(count_row("z", "5", 8'd1, 8'd5));
        directed_rows.push_back(count_row("9", 8'h00, 8'd4, 8'd5));
        directed_rows.push_back(count_row(8'hFF, 8'h00, 8'd0, 8'd1));
        directed_rows.push_back(count_row(8'h00, 8'hFF, 8'd0, 8'd21));
        directed_rows.push_back(count_row("A", "A", 8'd3, 8'd23));
        directed_rows.push_back(count_row("A", "A", 8'd0, 8'd20));
        directed_rows.push_back(count_row("Q", "x", 8'd14, 8'd255));
        directed_rows.push_back(count_row("Q", "x", 8'd255, 8'd255));
        directed_rows.push_back(read_row(9'h41, 1'b1, 32'd1));
        directed_rows.push_back(read_row(9'(PLACE_BASE), 1'b0, 32'd0));
        directed_rows.push_back(read_row(9'(PAIR_BASE + 1), 1'b0, 32'd0));
        directed_rows.push_back(read_row(9'(PAIR_BASE + 24), 1'b0, 32'd0));
        directed_rows.push_back(read_row(9'd0, 1'b0, 32'd0));
        directed_rows.push_back(read_row(9'd255, 1'b0, 32'd0));
        directed_rows.push_back(read_row(9'(PAIR_BASE + 25), 1'b1, 32'd0));
        // Byte zero and '!' marked special: a trailing zero now pairs as special.
        directed_rows.push_back(cfg_row(CFG_MASK_0, 64'h0000_0002_0000_0001));
        directed_rows.push_back(count_row("!", 8'h00, 8'd0, 8'd1));
        directed_rows.push_back(count_row(8'h00, "!", 8'd2, 8'd3));
        directed_rows.push_back(read_row(9'(PAIR_BASE + 18), 1'b0, 32'd0));
        directed_rows.push_back(read_row(9'(PLACE_BASE + 3), 1'b0, 32'd0));
        directed_rows.push_back(read_row(9'(PLACE_BASE + 11), 1'b0, 32'd0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain();
                write_mask(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
            end
            else
            begin
                send_req(directed_rows[i].req, directed_rows[i].cur, directed_rows[i].nxt,
                         directed_rows[i].pos, directed_rows[i].len, directed_rows[i].addr,
                         directed_rows[i].typed, directed_rows[i].want);
            end
        end

        drain();
        set_masks('1, '1, '1, '1);
        run_random(170);

        drain();
        set_masks('0, '0, '0, '0);
        run_random(170);

        drain();
        set_masks({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        run_random(170);

        // Ordinary punctuation, plus the top byte.
        drain();
        set_masks(64'hFC00_FFFF_0000_0000, 64'h7800_0001_F800_0001,
                  64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000);
        run_random(100);
        idle_on = 1'b0;
        run_random(100);

        @(negedge clk);
        in_valid <= 1'b0;
        while (reads_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
